/* design/bcld_pkg.sv */
// Package for the button click / long-click detector.
// Holds the phase type, the event codes and the register map.
// No dependencies.
package bcld_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned EVENT_W  = 2;
  localparam int unsigned IN_DW    = 40;
  localparam int unsigned OUT_DW   = 8;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 4;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_IN_PRESS   = 2'd1,
    PH_IN_RELEASE = 2'd2
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    REG_PRESS_TIME   = 2'd0,
    REG_RELEASE_TIME = 2'd1,
    REG_HOLD_TIME    = 2'd2
  } reg_idx_t;

endpackage

/* design/button_click_long_click_detector.sv */
// Top level of the button click / long-click detector.
// Uses bcld_pkg for the phase type, event codes and register map.
// Contains the whole datapath, the phase machine and the APB register file.

// The block takes one button poll per transfer on the in_ channel and returns
// exactly one result per poll on the out_ channel: no event, a click or a
// long click. Each poll carries the active-high pressed bit and a free-running
// millisecond timestamp that may wrap; all elapsed times are taken as wrapping
// 32-bit differences and compared strictly against the thresholds. A poll is
// accepted in every cycle in which the single output register is empty or is
// being drained, so the sustained rate is one poll per clock cycle unless the
// output stalls; the result is valid in the cycle after its poll. The step is
// one 32-bit subtract per timer and its compares, feeding the phase update,
// all between the phase registers and the result register. The three 16-bit
// thresholds are written over the APB port and should only be changed while
// no result is pending; new values apply to the next accepted poll.
module button_click_long_click_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel. in_tdata: [0] button_pressed, [32:1] now_ms, [39:33] zero.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bcld_pkg::IN_DW-1:0]          in_tdata,
  // Result channel. out_tdata: [1:0] click_event, [7:2] zero.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bcld_pkg::OUT_DW-1:0]         out_tdata,
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [bcld_pkg::APB_AW-1:0]         cfg_paddr,
  input  logic [bcld_pkg::APB_DW-1:0]         cfg_pwdata,
  output logic [bcld_pkg::APB_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready
);

  // Threshold registers.
  logic [bcld_pkg::CFG_W-1:0] press_time_r;
  logic [bcld_pkg::CFG_W-1:0] release_time_r;
  logic [bcld_pkg::CFG_W-1:0] hold_time_r;

  // Phase machine state.
  bcld_pkg::phase_t            phase_r, phase_nxt;
  logic [bcld_pkg::TIME_W-1:0] press_start_r, press_start_nxt;
  logic [bcld_pkg::TIME_W-1:0] release_start_r, release_start_nxt;
  logic                        held_r, held_nxt;

  // Result register.
  logic                        out_valid_r;
  bcld_pkg::event_t            out_event_r;
  bcld_pkg::event_t            event_nxt;

  logic                        in_fire;
  logic                        cfg_wr;
  logic [1:0]                  cfg_idx;
  logic                        pressed;
  logic [bcld_pkg::TIME_W-1:0] now_ms;
  logic [bcld_pkg::TIME_W-1:0] press_elapsed;
  logic [bcld_pkg::TIME_W-1:0] release_elapsed;
  logic                        press_over;
  logic                        release_over;
  logic                        hold_over;

  // ---------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied
  // high so no wait states are ever inserted.
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_time_r   <= '0;
      release_time_r <= '0;
      hold_time_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bcld_pkg::REG_PRESS_TIME:   press_time_r   <= cfg_pwdata[bcld_pkg::CFG_W-1:0];
        bcld_pkg::REG_RELEASE_TIME: release_time_r <= cfg_pwdata[bcld_pkg::CFG_W-1:0];
        bcld_pkg::REG_HOLD_TIME:    hold_time_r    <= cfg_pwdata[bcld_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      bcld_pkg::REG_PRESS_TIME:   cfg_prdata[bcld_pkg::CFG_W-1:0] = press_time_r;
      bcld_pkg::REG_RELEASE_TIME: cfg_prdata[bcld_pkg::CFG_W-1:0] = release_time_r;
      bcld_pkg::REG_HOLD_TIME:    cfg_prdata[bcld_pkg::CFG_W-1:0] = hold_time_r;
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input handshake. A poll is taken whenever the result register is free
  // or is emptied in the same cycle.
  // ---------------------------------------------------------------------
  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;

  assign pressed = in_tdata[0];
  assign now_ms  = in_tdata[bcld_pkg::TIME_W:1];

  // Wrapping elapsed times and strict threshold compares.
  assign press_elapsed   = now_ms - press_start_r;
  assign release_elapsed = now_ms - release_start_r;
  assign press_over   = press_elapsed   > {{(bcld_pkg::TIME_W-bcld_pkg::CFG_W){1'b0}}, press_time_r};
  assign hold_over    = press_elapsed   > {{(bcld_pkg::TIME_W-bcld_pkg::CFG_W){1'b0}}, hold_time_r};
  assign release_over = release_elapsed > {{(bcld_pkg::TIME_W-bcld_pkg::CFG_W){1'b0}}, release_time_r};

  // Next-state logic of the phase machine.
  always_comb begin
    phase_nxt         = phase_r;
    press_start_nxt   = press_start_r;
    release_start_nxt = release_start_r;
    held_nxt          = held_r;
    unique case (phase_r)
      bcld_pkg::PH_IN_PRESS: begin
        if (!pressed) begin
          // A release that comes too early is ignored and the press goes on.
          if (press_over) begin
            phase_nxt         = bcld_pkg::PH_IN_RELEASE;
            release_start_nxt = now_ms;
          end
        end else if (hold_over) begin
          held_nxt = 1'b1;
        end
      end
      bcld_pkg::PH_IN_RELEASE: begin
        // The button bit is not looked at while the release settles.
        if (release_over) begin
          phase_nxt = bcld_pkg::PH_IDLE;
          held_nxt  = 1'b0;
        end
      end
      default: begin
        // Idle, and the unused phase code, which behaves as idle.
        phase_nxt = bcld_pkg::PH_IDLE;
        if (pressed) begin
          phase_nxt       = bcld_pkg::PH_IN_PRESS;
          press_start_nxt = now_ms;
        end
      end
    endcase
  end

  // Output logic of the phase machine: the event reported for this poll.
  always_comb begin
    event_nxt = bcld_pkg::EV_NONE;
    unique case (phase_r)
      bcld_pkg::PH_IN_RELEASE: begin
        if (release_over) begin
          event_nxt = held_r ? bcld_pkg::EV_LONG : bcld_pkg::EV_CLICK;
        end
      end
      default: event_nxt = bcld_pkg::EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= bcld_pkg::PH_IDLE;
      press_start_r   <= '0;
      release_start_r <= '0;
      held_r          <= 1'b0;
    end else if (in_fire) begin
      phase_r         <= phase_nxt;
      press_start_r   <= press_start_nxt;
      release_start_r <= release_start_nxt;
      held_r          <= held_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register. Loaded on every accepted poll, cleared when the
  // result transfer completes without a new poll behind it.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_event_r <= event_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bcld_pkg::OUT_DW-bcld_pkg::EVENT_W){1'b0}}, out_event_r};

endmodule

/* verif/tb_button_click_long_click_detector.sv */
// Self-checking testbench for the button click / long-click detector.
// Depends on bcld_pkg and button_click_long_click_detector from the design folder.
// Drives polls over the stream input, configures thresholds over APB, checks every result.
module tb_button_click_long_click_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import bcld_pkg::*;

  // How the three thresholds of one random phase are chosen.
  typedef enum {THR_ZERO, THR_MAX, THR_SMALL, THR_MIXED} thr_mode_t;

  // Address 12 decodes to no register; writes there must leave everything alone.
  localparam logic [APB_AW-1:0] UNMAPPED_ADDR = 4'hC;

  // Our own view of the detector: its phase, both timestamps and the held mark.
  typedef struct packed {
    phase_t      ph;
    logic [31:0] press_at;
    logic [31:0] release_at;
    logic        held;
  } detector_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;   // [0] button_pressed, [32:1] now_ms, [39:33] zero
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;  // [1:0] click_event, [7:2] zero
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [APB_AW-1:0]   cfg_paddr;
  logic [APB_DW-1:0]   cfg_pwdata;
  logic [APB_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  detector_t   btn;
  logic [15:0] thr_press;
  logic [15:0] thr_release;
  logic [15:0] thr_hold;
  event_t      expected_clicks[$];
  int unsigned mismatches;
  // Once set, neither side inserts idle cycles any more.
  bit          steady;

  button_click_long_click_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("[button_click_long_click_detector] ERROR");
    $finish;
  end

  // Advances our copy of the detector by one poll and returns the event it reports.
  // Elapsed times are plain 32-bit differences, so a timestamp wrap is handled for free.
  function automatic event_t next_click_event(input logic pressed, input logic [31:0] now_ms);
    logic [31:0] since_press;
    logic [31:0] since_release;
    event_t      ev;
    ev = EV_NONE;
    since_press = now_ms - btn.press_at;
    since_release = now_ms - btn.release_at;
    case (btn.ph)
      PH_IN_PRESS: begin
        if (!pressed) begin
          // A release only counts once the press has lasted longer than press_time.
          if (since_press > {16'd0, thr_press}) begin
            btn.ph = PH_IN_RELEASE;
            btn.release_at = now_ms;
          end
        end else if (since_press > {16'd0, thr_hold}) begin
          btn.held = 1'b1;
        end
      end
      PH_IN_RELEASE: begin
        // The button bit is ignored here; only the settle time matters.
        if (since_release > {16'd0, thr_release}) begin
          btn.ph = PH_IDLE;
          if (btn.held) begin
            btn.held = 1'b0;
            ev = EV_LONG;
          end else begin
            ev = EV_CLICK;
          end
        end
      end
      default: begin
        btn.ph = PH_IDLE;
        if (pressed) begin
          btn.press_at = now_ms;
          btn.ph = PH_IN_PRESS;
        end
      end
    endcase
    return ev;
  endfunction

  // A time step that often lands exactly on a threshold or one past it.
  function automatic logic [31:0] step_ms(input logic [15:0] thr);
    logic [31:0] span;
    span = {16'd0, thr};
    case ($urandom_range(0, 3))
      0: return span;
      1: return span + 32'd1;
      default: return $urandom_range(0, span + span / 2 + 32'd2);
    endcase
  endfunction

  function automatic logic [15:0] pick_threshold(input thr_mode_t mode);
    case (mode)
      THR_ZERO:  return 16'd0;
      THR_MAX:   return 16'hFFFF;
      THR_SMALL: return 16'($urandom_range(0, 12));
      default:   return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 12))
                                                    : 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Sends one poll and records the event it must produce. The transfer completes
  // at the first rising edge with tready high; tvalid stays up for the next poll.
  task automatic poll(input logic pressed, input logic [31:0] now_ms);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DW - 33){1'b0}}, now_ms, pressed};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_clicks.push_back(next_click_event(pressed, now_ms));
  endtask

  // Stops input and waits until every expected result has been seen, so that
  // the thresholds can be changed safely. The block answers in the cycle after a
  // poll, so a short pause covers anything still in flight.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_clicks.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // APB write: setup phase, then access phase until pready, then an idle phase.
  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    // Only the low 16 bits are kept; the unmapped address changes nothing.
    if (addr[1:0] == 2'b00) begin
      case (addr[APB_AW-1:2])
        REG_PRESS_TIME:   thr_press = value[15:0];
        REG_RELEASE_TIME: thr_release = value[15:0];
        REG_HOLD_TIME:    thr_hold = value[15:0];
        default: ;
      endcase
    end
    @(posedge clk);
  endtask

  // One press, some held polls, a release (possibly too early) and a few polls
  // afterwards with a random button bit, starting at a random timestamp.
  task automatic press_and_release();
    logic [31:0] t;
    t = $urandom();
    poll(1'b1, t);
    repeat ($urandom_range(0, 4)) begin
      t += step_ms(thr_hold);
      poll(1'b1, t);
    end
    t += step_ms(thr_press);
    poll(1'b0, t);
    repeat ($urandom_range(1, 4)) begin
      t += step_ms(thr_release);
      poll(1'($urandom_range(0, 1)), t);
    end
  endtask

  // Reset thresholds are all zero: every elapsed time of one or more counts.
  // Covers a release too early, the button being ignored during release, a long
  // click and a plain click, with now_ms starting at zero.
  task automatic test_zero_thresholds();
    poll(1'b0, 32'd0);
    poll(1'b1, 32'd10);
    poll(1'b1, 32'd10);
    poll(1'b0, 32'd10);
    poll(1'b1, 32'd11);
    poll(1'b0, 32'd11);
    poll(1'b1, 32'd11);
    poll(1'b1, 32'd12);
    poll(1'b1, 32'd20);
    poll(1'b0, 32'd21);
    poll(1'b0, 32'd22);
  endtask

  // All thresholds at their maximum, written with junk in the upper data bits,
  // plus a write to the unmapped address. The press starts at the top of the
  // timestamp range so every press-timer comparison happens across the wrap.
  task automatic test_max_thresholds();
    logic [31:0] t;
    drain();
    write_reg({REG_PRESS_TIME, 2'b00}, 32'hFFFF_FFFF);
    write_reg({REG_RELEASE_TIME, 2'b00}, 32'hFFFF_FFFF);
    write_reg({REG_HOLD_TIME, 2'b00}, 32'hFFFF_FFFF);
    write_reg(UNMAPPED_ADDR, 32'h0000_0001);
    t = 32'hFFFF_FFFF;
    poll(1'b1, t);
    poll(1'b1, t + 32'd65535);
    poll(1'b0, t + 32'd65535);
    poll(1'b1, t + 32'd65536);
    poll(1'b0, t + 32'd65536);
    t = t + 32'd65536;
    poll(1'b0, t + 32'd65535);
    poll(1'b1, t + 32'd65536);
  endtask

  // The hold threshold is lowered while a press is in progress; the new value
  // must apply to the very next poll without disturbing the press.
  task automatic test_write_mid_press();
    drain();
    write_reg({REG_PRESS_TIME, 2'b00}, 32'd3);
    write_reg({REG_RELEASE_TIME, 2'b00}, 32'd2);
    write_reg({REG_HOLD_TIME, 2'b00}, 32'd100);
    poll(1'b1, 32'd1000);
    poll(1'b1, 32'd1050);
    drain();
    write_reg({REG_HOLD_TIME, 2'b00}, 32'd20);
    poll(1'b1, 32'd1060);
    poll(1'b0, 32'd1064);
    poll(1'b0, 32'd1067);
  endtask

  // One configuration phase: new thresholds, then mostly well-formed presses
  // with an occasional stray poll at a fully random timestamp.
  task automatic test_random_sequences(input thr_mode_t mode, input int unsigned count);
    drain();
    write_reg({REG_PRESS_TIME, 2'b00}, {16'($urandom()), pick_threshold(mode)});
    write_reg({REG_RELEASE_TIME, 2'b00}, {16'($urandom()), pick_threshold(mode)});
    write_reg({REG_HOLD_TIME, 2'b00}, {16'($urandom()), pick_threshold(mode)});
    if ($urandom_range(0, 1) != 0) write_reg(UNMAPPED_ADDR, $urandom());
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) poll(1'($urandom_range(0, 1)), $urandom());
      else press_and_release();
    end
  endtask

  // Result side: random stalls in bursts until the quiet final part.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!steady && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Every result transfer is matched against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_clicks.size() == 0) begin
        $display("%0t: unexpected result, expected nothing, got click_event %0d",
                 $time, out_tdata[EVENT_W-1:0]);
        mismatches++;
      end else begin
        if (out_tdata[EVENT_W-1:0] !== expected_clicks[0]) begin
          $display("%0t: click_event mismatch, expected %0d, got %0d",
                   $time, expected_clicks[0], out_tdata[EVENT_W-1:0]);
          mismatches++;
        end
        void'(expected_clicks.pop_front());
      end
    end
  end

  initial begin
    mismatches = 0;
    steady = 1'b0;
    btn = '{ph: PH_IDLE, press_at: 32'd0, release_at: 32'd0, held: 1'b0};
    thr_press = 16'd0;
    thr_release = 16'd0;
    thr_hold = 16'd0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_zero_thresholds();
    test_max_thresholds();
    test_write_mid_press();
    test_random_sequences(THR_ZERO, 18);
    test_random_sequences(THR_MAX, 18);
    test_random_sequences(THR_SMALL, 18);
    test_random_sequences(THR_SMALL, 18);
    test_random_sequences(THR_MIXED, 18);
    // Final stretch runs at full rate on both sides.
    drain();
    steady = 1'b1;
    test_random_sequences(THR_SMALL, 12);
    drain();

    if (mismatches == 0) begin
      $display("[button_click_long_click_detector] OK");
    end else begin
      $display("[button_click_long_click_detector] ERROR");
    end
    $finish;
  end

endmodule

/* button_click_long_click_detector.f */
design/bcld_pkg.sv
design/button_click_long_click_detector.sv
verif/tb_button_click_long_click_detector.sv
